// ===== rtl/tie_pkg.sv =====
package tie_pkg;

	// Store sizes
	localparam int DATA_WORDS = 4096;
	localparam int REG_COUNT  = 32;
	localparam int DATA_AW    = $clog2(DATA_WORDS);
	localparam int REG_AW     = $clog2(REG_COUNT);

	// Exact load/store address: 32-bit base plus 32-bit offset, signed
	localparam int ADDR_W = 34;

	localparam logic [15:0] RESET_PC = 16'd4000;
	localparam logic [15:0] PC_STEP  = 16'd4;

	typedef enum logic [4:0] {
		CMD_STORE = 5'd0,
		CMD_STR   = 5'd1,
		CMD_MOVC  = 5'd2,
		CMD_ADD   = 5'd3,
		CMD_ADDL  = 5'd4,
		CMD_SUB   = 5'd5,
		CMD_SUBL  = 5'd6,
		CMD_MUL   = 5'd7,
		CMD_AND   = 5'd8,
		CMD_OR    = 5'd9,
		CMD_XOR   = 5'd10,
		CMD_LOAD  = 5'd11,
		CMD_LDR   = 5'd12,
		CMD_BZ    = 5'd13,
		CMD_BNZ   = 5'd14,
		CMD_JUMP  = 5'd15,
		CMD_HALT  = 5'd16,
		CMD_NOP   = 5'd17
	} cmd_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RDB,
		S_RDC,
		S_RDD,
		S_CAPD,
		S_EXEC,
		S_MEM,
		S_LOADW,
		S_FINISH
	} state_t;

	// Result of the execute unit for one item
	typedef struct packed {
		logic [31:0]       val;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       npc;
		logic              wr;
		logic              setz;
		logic              zclr;
		logic              memop;
		logic              store;
		logic              load;
		logic              halt;
	} exec_t;

endpackage

// ===== rtl/tie_ram.sv =====
module tie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, read one word with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tie_regfile.sv =====
module tie_regfile import tie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [4:0]  raddr,
	output logic [31:0] rdata,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [31:0] wdata
);

	logic [REG_COUNT-1:0] valid_q;
	logic [REG_AW-1:0]    ridx_s1;
	logic                 rok_s1;
	logic [31:0]          ram_rdata;

	tie_ram #(
		.WIDTH(32),
		.DEPTH(REG_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr[REG_AW-1:0]),
		.wdata(wdata),
		.raddr(raddr[REG_AW-1:0]),
		.rdata(ram_rdata)
	);

	// Mark written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr[REG_AW-1:0]] <= 1'b1;
		end
	end

	// Track the read address alongside the RAM latency
	always_ff @(posedge clk) begin
		ridx_s1 <= raddr[REG_AW-1:0];
		rok_s1  <= ({1'b0, raddr} < 6'(REG_COUNT));
	end

	assign rdata = (rok_s1 && valid_q[ridx_s1]) ? ram_rdata : 32'd0;

endmodule

// ===== rtl/tie_exec.sv =====
module tie_exec import tie_pkg::*; (
	input  cmd_t        cmd,
	input  logic [15:0] imm,
	input  logic [15:0] pc,
	input  logic        zero,
	input  logic [31:0] va,
	input  logic [31:0] vb,
	input  logic [31:0] vc,
	input  logic [31:0] vd,
	output exec_t       ex
);

	logic [31:0]       immw;
	logic [17:0]       br_t;
	logic [17:0]       br_abs;
	logic [15:0]       jp_t;
	logic [31:0]       base;
	logic [31:0]       offs;
	logic [ADDR_W-1:0] addr;

	// Sign-extend the literal; form branch and jump targets
	assign immw   = {{16{imm[15]}}, imm};
	assign br_t   = {2'b00, pc} + {{2{imm[15]}}, imm};
	assign br_abs = br_t[17] ? (18'd0 - br_t) : br_t;
	assign jp_t   = vd[15:0] + imm;

	// Exact memory address: base plus literal or index register
	always_comb begin
		base = ((cmd == CMD_STORE) || (cmd == CMD_STR)) ? vb : va;
		case (cmd)
			CMD_STORE, CMD_LOAD: offs = immw;
			CMD_STR:             offs = vc;
			default:             offs = vb;
		endcase
		addr = {{2{base[31]}}, base} + {{2{offs[31]}}, offs};
	end

	// Decode and compute
	always_comb begin
		ex       = '0;
		ex.addr  = addr;
		ex.npc   = pc + PC_STEP;
		unique case (cmd)
			CMD_STORE, CMD_STR: begin
				ex.memop = 1'b1;
				ex.store = 1'b1;
			end
			CMD_MOVC: begin
				ex.val = immw;
				ex.wr  = 1'b1;
			end
			CMD_ADD: begin
				ex.val  = va + vb;
				ex.wr   = 1'b1;
				ex.setz = 1'b1;
			end
			CMD_ADDL: begin
				ex.val  = va + immw;
				ex.wr   = 1'b1;
				ex.setz = 1'b1;
			end
			CMD_SUB: begin
				ex.val  = va - vb;
				ex.wr   = 1'b1;
				ex.setz = 1'b1;
			end
			CMD_SUBL: begin
				ex.val  = va - immw;
				ex.wr   = 1'b1;
				ex.setz = 1'b1;
			end
			CMD_MUL: begin
				ex.val  = va * vb;
				ex.wr   = 1'b1;
				ex.setz = 1'b1;
			end
			CMD_AND: begin
				ex.val = va & vb;
				ex.wr  = 1'b1;
			end
			CMD_OR: begin
				ex.val = va | vb;
				ex.wr  = 1'b1;
			end
			CMD_XOR: begin
				ex.val = va ^ vb;
				ex.wr  = 1'b1;
			end
			CMD_LOAD, CMD_LDR: begin
				ex.memop = 1'b1;
				ex.load  = 1'b1;
				ex.wr    = 1'b1;
			end
			CMD_BZ, CMD_BNZ: begin
				ex.zclr = 1'b1;
				if ((cmd == CMD_BZ) == zero) begin
					ex.npc = {br_abs[15:2], 2'b00};
				end
			end
			CMD_JUMP: begin
				ex.npc = {jp_t[15:2], 2'b00};
			end
			CMD_HALT: begin
				ex.halt = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/teaching_isa_instruction_executor.sv =====
// Channel  Handshake           Payload
// in       in_valid/in_ready   command dest_reg src_a src_b src_c immediate
// out      out_valid/out_ready exec_pc next_pc reg_write reg_index reg_value
//                              mem_write mem_index mem_value zflag halted addr_error
// An item runs through the operand reads and execute, then for a store or a load a
// memory step and, for a load with a good address, a data wait; once halted it goes
// straight to the final state. The single read port of the register file takes four
// operand reads. After reset the data store is cleared one word a cycle, all 4096
// words, before the first item is taken. A result waits in the output register; the
// next item is accepted meanwhile and holds in its final state until the result is taken.
module teaching_isa_instruction_executor import tie_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         command,
	input  logic [4:0]         dest_reg,
	input  logic [4:0]         src_a,
	input  logic [4:0]         src_b,
	input  logic [4:0]         src_c,
	input  logic signed [15:0] immediate,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        exec_pc,
	output logic [15:0]        next_pc,
	output logic               reg_write,
	output logic [4:0]         reg_index,
	output logic signed [31:0] reg_value,
	output logic               mem_write,
	output logic [11:0]        mem_index,
	output logic signed [31:0] mem_value,
	output logic               zflag,
	output logic               halted,
	output logic               addr_error
);

	state_t state_q, state_d;

	// Architectural control state
	logic [15:0] pc_q;
	logic        zero_q;
	logic        halt_q;
	logic [DATA_AW-1:0] clr_q;

	// Item being worked on
	cmd_t        cmd_q;
	logic [4:0]  rd_q, rb_q, rc_q;
	logic [15:0] imm_q;
	logic [31:0] va_q, vb_q, vc_q, vd_q;
	exec_t       ex_d, ex_q;
	logic        err_q;
	logic [31:0] mval_q;

	// Output register
	logic        out_valid_q;
	logic [15:0] exec_pc_q, next_pc_q;
	logic        reg_write_q, mem_write_q, zflag_q, halted_q, addr_error_q;
	logic [4:0]  reg_index_q;
	logic [31:0] reg_value_q, mem_value_q;
	logic [11:0] mem_index_q;

	// Memory ports and control
	logic [4:0]         rf_raddr;
	logic [31:0]        rf_rdata;
	logic               rf_we;
	logic               ds_we;
	logic [DATA_AW-1:0] ds_addr;
	logic [31:0]        ds_wdata;
	logic [31:0]        ds_rdata;
	logic               accept;
	logic               fin;
	logic               addr_ok;
	logic               rd_ok;
	logic               wr_f;
	logic [31:0]        val_f;
	logic               zero_f;

	tie_regfile u_regfile (
		.clk   (clk),
		.arst_n(arst_n),
		.raddr (rf_raddr),
		.rdata (rf_rdata),
		.we    (rf_we),
		.waddr (rd_q),
		.wdata (val_f)
	);

	tie_ram #(
		.WIDTH(32),
		.DEPTH(DATA_WORDS)
	) u_data_store (
		.clk  (clk),
		.we   (ds_we),
		.waddr(ds_addr),
		.wdata(ds_wdata),
		.raddr(ds_addr),
		.rdata(ds_rdata)
	);

	tie_exec u_exec (
		.cmd (cmd_q),
		.imm (imm_q),
		.pc  (pc_q),
		.zero(zero_q),
		.va  (va_q),
		.vb  (vb_q),
		.vc  (vc_q),
		.vd  (vd_q),
		.ex  (ex_d)
	);

	// Address range check and final write-back values
	assign addr_ok = !ex_q.addr[ADDR_W-1] && (ex_q.addr < ADDR_W'(DATA_WORDS));
	assign rd_ok   = ({1'b0, rd_q} < 6'(REG_COUNT));
	assign wr_f    = !halt_q && ex_q.wr && !(ex_q.load && err_q) && rd_ok;
	assign val_f   = ex_q.load ? mval_q : ex_q.val;
	assign zero_f  = ex_q.zclr ? 1'b0 : (ex_q.setz ? (ex_q.val == 32'd0) : zero_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (clr_q == DATA_AW'(DATA_WORDS - 1)) state_d = S_IDLE;
			S_IDLE:   if (in_valid) state_d = halt_q ? S_FINISH : S_RDB;
			S_RDB:    state_d = S_RDC;
			S_RDC:    state_d = S_RDD;
			S_RDD:    state_d = S_CAPD;
			S_CAPD:   state_d = S_EXEC;
			S_EXEC:   state_d = ex_d.memop ? S_MEM : S_FINISH;
			S_MEM:    state_d = (ex_q.load && addr_ok) ? S_LOADW : S_FINISH;
			S_LOADW:  state_d = S_FINISH;
			S_FINISH: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		in_ready = 1'b0;
		rf_raddr = src_a;
		rf_we    = 1'b0;
		ds_we    = 1'b0;
		ds_addr  = ex_q.addr[DATA_AW-1:0];
		ds_wdata = va_q;
		fin      = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ds_we    = 1'b1;
				ds_addr  = clr_q;
				ds_wdata = 32'd0;
			end
			S_IDLE:  in_ready = 1'b1;
			S_RDB:   rf_raddr = rb_q;
			S_RDC:   rf_raddr = rc_q;
			S_RDD:   rf_raddr = rd_q;
			S_MEM:   ds_we = ex_q.store && addr_ok;
			S_FINISH: begin
				fin   = !out_valid_q || out_ready;
				rf_we = fin && wr_f;
			end
			default: begin
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pc_q    <= RESET_PC;
			zero_q  <= 1'b0;
			halt_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (fin && !halt_q) begin
				pc_q   <= ex_q.npc;
				zero_q <= zero_f;
				halt_q <= ex_q.halt;
			end
		end
	end

	// Capture the item, its operands and intermediate results
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(command);
			rd_q  <= dest_reg;
			rb_q  <= src_b;
			rc_q  <= src_c;
			imm_q <= immediate;
		end
		unique case (state_q)
			S_RDB:  va_q <= rf_rdata;
			S_RDC:  vb_q <= rf_rdata;
			S_RDD:  vc_q <= rf_rdata;
			S_CAPD: vd_q <= rf_rdata;
			S_EXEC: begin
				ex_q   <= ex_d;
				err_q  <= 1'b0;
				mval_q <= 32'd0;
			end
			S_MEM: begin
				err_q <= !addr_ok;
				if (ex_q.store && addr_ok) begin
					mval_q <= va_q;
				end
			end
			S_LOADW: mval_q <= ds_rdata;
			default: begin
			end
		endcase
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			exec_pc_q <= pc_q;
			if (halt_q) begin
				next_pc_q    <= pc_q;
				reg_write_q  <= 1'b0;
				reg_index_q  <= 5'd0;
				reg_value_q  <= 32'd0;
				mem_write_q  <= 1'b0;
				mem_index_q  <= 12'd0;
				mem_value_q  <= 32'd0;
				zflag_q      <= zero_q;
				halted_q     <= 1'b1;
				addr_error_q <= 1'b0;
			end else begin
				next_pc_q    <= ex_q.npc;
				reg_write_q  <= wr_f;
				reg_index_q  <= wr_f ? rd_q : 5'd0;
				reg_value_q  <= wr_f ? val_f : 32'd0;
				mem_write_q  <= ex_q.store && !err_q;
				mem_index_q  <= (ex_q.memop && !err_q) ? ex_q.addr[11:0] : 12'd0;
				mem_value_q  <= (ex_q.memop && !err_q) ? mval_q : 32'd0;
				zflag_q      <= zero_f;
				halted_q     <= ex_q.halt;
				addr_error_q <= ex_q.memop && err_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign exec_pc    = exec_pc_q;
	assign next_pc    = next_pc_q;
	assign reg_write  = reg_write_q;
	assign reg_index  = reg_index_q;
	assign reg_value  = reg_value_q;
	assign mem_write  = mem_write_q;
	assign mem_index  = mem_index_q;
	assign mem_value  = mem_value_q;
	assign zflag      = zflag_q;
	assign halted     = halted_q;
	assign addr_error = addr_error_q;

endmodule

// ===== rtl/tie_checker.sv =====
module tie_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [15:0]        exec_pc,
	input logic [15:0]        next_pc,
	input logic               reg_write,
	input logic [4:0]         reg_index,
	input logic signed [31:0] reg_value,
	input logic               mem_write,
	input logic [11:0]        mem_index,
	input logic               addr_error
);

	// A stalled result keeps its program counters
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(exec_pc) && $stable(next_pc))
		else $error("result changed while stalled");

	// One item at a time: no acceptance right after another
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in work");

	// A bad address writes nothing and reports no index
	a_addr_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && addr_error |-> !mem_write && !reg_write && (mem_index == 12'd0))
		else $error("address error with side effects");

	// No register write means empty register fields
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_write |-> (reg_index == 5'd0) && (reg_value == 32'sd0))
		else $error("register fields set without a write");

endmodule

bind teaching_isa_instruction_executor tie_checker u_tie_checker (.*);
